### sv/rotation_matrix_to_euler_angles_macros.svh
// Assertion macros used by the RMTE top-level RTL file.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rmte_pkg.sv
// Shared constants, types and functions for the rotation-to-Euler block.
package rmte_pkg;

    // default parameter values
    localparam int ELEMENT_WIDTH_DEF = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // guard bits added below each element
    localparam int GUARD = 8;
    // angle accumulator width, units of 2^-24 rad
    localparam int ZW = 28;
    localparam int OUT_LSB = 11;
    localparam int INVK_W = 21;

    localparam logic signed [ZW-1:0] PI_Z = ZW'(52707179);
    localparam logic [INVK_W-1:0] INVK_Q21 = INVK_W'(1273502);
    localparam logic signed [17:0] PI_OUT = 18'sd25736;
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1024);

    // configuration register indexes
    localparam logic [1:0] CFG_AXIS_ORDER = 2'd0;
    localparam logic [1:0] CFG_POSITIVE_BETA = 2'd1;
    localparam logic [1:0] CFG_SINGULAR_THRESHOLD = 2'd2;

    // flags captured before vectoring starts
    typedef struct packed {
        logic yzero;
        logic xneg;
    } t_vflags;

    // arctangent of 2^-i in units of 2^-24 rad
    function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
        logic signed [ZW-1:0] r;
        case (i)
            0: r = ZW'(13176795);
            1: r = ZW'(7778716);
            2: r = ZW'(4110060);
            3: r = ZW'(2086331);
            4: r = ZW'(1047214);
            5: r = ZW'(524117);
            6: r = ZW'(262123);
            7: r = ZW'(131069);
            8: r = ZW'(65536);
            default: begin
                if (i <= 24) r = ZW'(1) <<< (24 - i);
                else r = '0;
            end
        endcase
        return r;
    endfunction

    // next axis in cyclic order
    function automatic logic [1:0] next_axis(input logic [2:0] n);
        logic [1:0] r;
        case (n)
            3'd0: r = 2'd1;
            3'd1: r = 2'd2;
            3'd2: r = 2'd0;
            3'd3: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/rmte_cell.sv
// One CORDIC vectoring iteration with its pipeline register.
module rmte_cell #(
    parameter int XW = 27,
    parameter int SW = 1,
    parameter int STAGE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    input  logic signed [rmte_pkg::ZW-1:0] i_z,
    input  logic [SW-1:0]                 i_sb,
    output logic                          o_valid,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic signed [rmte_pkg::ZW-1:0] o_z,
    output logic [SW-1:0]                 o_sb
);
    localparam logic signed [rmte_pkg::ZW-1:0] ATAN = rmte_pkg::atan_step(STAGE);

    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [rmte_pkg::ZW-1:0] n_z;

    // rotate toward the x axis
    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (i_y > 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_x  <= n_x;
        o_y  <= n_y;
        o_z  <= n_z;
        o_sb <= i_sb;
    end
endmodule

### sv/rmte_vec.sv
// Pipelined CORDIC vectoring unit: pre-rotation register plus a chain of cells.
module rmte_vec #(
    parameter int XW = 27,
    parameter int SW = 1,
    parameter int STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [XW-1:0]          i_y,
    input  logic signed [XW-1:0]          i_x,
    input  logic [SW-1:0]                 i_sb,
    output logic                          o_valid,
    output logic signed [XW-1:0]          o_mag,
    output logic signed [rmte_pkg::ZW-1:0] o_z,
    output logic [SW-1:0]                 o_sb
);
    localparam int FW = $bits(rmte_pkg::t_vflags);
    localparam int CW = SW + FW;

    logic                           r_valid;
    logic signed [XW-1:0]           r_x, r_y;
    logic signed [rmte_pkg::ZW-1:0] r_z;
    logic [CW-1:0]                  r_sb;

    logic signed [XW-1:0]           n_x, n_y;
    logic signed [rmte_pkg::ZW-1:0] n_z;
    rmte_pkg::t_vflags              n_fl, out_fl;

    logic                           c_valid [STAGES+1];
    logic signed [XW-1:0]           c_x [STAGES+1];
    logic signed [XW-1:0]           c_y [STAGES+1];
    logic signed [rmte_pkg::ZW-1:0] c_z [STAGES+1];
    logic [CW-1:0]                  c_sb [STAGES+1];

    // fold a negative abscissa by a half turn
    always_comb begin
        n_fl.yzero = (i_y == '0);
        n_fl.xneg  = i_x[XW-1];
        if (i_x[XW-1]) begin
            n_x = -i_x;
            n_y = -i_y;
            n_z = (i_y > 0) ? rmte_pkg::PI_Z : -rmte_pkg::PI_Z;
        end else begin
            n_x = i_x;
            n_y = i_y;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_y  <= n_y;
        r_z  <= n_z;
        r_sb <= {i_sb, n_fl};
    end

    assign c_valid[0] = r_valid;
    assign c_x[0]     = r_x;
    assign c_y[0]     = r_y;
    assign c_z[0]     = r_z;
    assign c_sb[0]    = r_sb;

    // iteration chain
    for (genvar s = 0; s < STAGES; s++) begin : g_cell
        rmte_cell #(.XW(XW), .SW(CW), .STAGE(s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[s]),
            .i_x     (c_x[s]),
            .i_y     (c_y[s]),
            .i_z     (c_z[s]),
            .i_sb    (c_sb[s]),
            .o_valid (c_valid[s+1]),
            .o_x     (c_x[s+1]),
            .o_y     (c_y[s+1]),
            .o_z     (c_z[s+1]),
            .o_sb    (c_sb[s+1])
        );
    end

    // exact angle on the x axis
    always_comb begin
        out_fl = c_sb[STAGES][FW-1:0];
        if (out_fl.yzero) o_z = out_fl.xneg ? rmte_pkg::PI_Z : '0;
        else o_z = c_z[STAGES];
    end

    assign o_valid = c_valid[STAGES];
    assign o_mag   = c_x[STAGES];
    assign o_sb    = c_sb[STAGES][CW-1:FW];
endmodule

### sv/rotation_matrix_to_euler_angles.sv
// Top level: rotation matrix to Euler angles, all 24 axis orders.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  command  | i_start / o_busy    | i_m00 .. i_m22
//  result   | o_valid (strobe)    | o_alpha_angle, o_beta_angle,
//           |                     | o_gamma_angle, o_near_singular
//  config   | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One matrix is taken every cycle; o_busy stays low.
// Registers in order: input register, two CORDIC
// chains of CORDIC_STAGES+1 registers, the gain multiply and the output.
// Reset clears the valid pipeline and loads the register defaults.
// The result strobe cannot be held off; each word is shown for one cycle.
`include "rotation_matrix_to_euler_angles_macros.svh"

module rotation_matrix_to_euler_angles #(
    parameter int ELEMENT_WIDTH = rmte_pkg::ELEMENT_WIDTH_DEF,
    parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m00,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m01,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m02,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m10,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m11,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m12,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m20,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m21,
    input  logic signed [ELEMENT_WIDTH-1:0] i_m22,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [7:0]                      i_cfg_data,
    output logic                            o_valid,
    output logic signed [16:0]              o_alpha_angle,
    output logic signed [15:0]              o_beta_angle,
    output logic signed [16:0]              o_gamma_angle,
    output logic                            o_near_singular
);
    localparam int EW = ELEMENT_WIDTH;
    localparam int ZW = rmte_pkg::ZW;
    localparam int XW = EW + rmte_pkg::GUARD + 3;
    localparam int PW = XW + rmte_pkg::INVK_W;
    localparam int DSW = 2 * ZW + 1;

    // configuration registers
    logic [4:0] r_order;
    logic       r_pos;
    logic [7:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 5'd0;
            r_pos   <= 1'b0;
            r_thr   <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rmte_pkg::CFG_AXIS_ORDER:         r_order <= i_cfg_data[4:0];
                rmte_pkg::CFG_POSITIVE_BETA:      r_pos   <= i_cfg_data[0];
                rmte_pkg::CFG_SINGULAR_THRESHOLD: r_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // order code fields
    logic       fr, rep, par;
    logic [1:0] ax, ai, aj, ak;
    always_comb begin
        fr  = r_order[0];
        rep = r_order[1];
        par = r_order[2];
        ax  = r_order[4:3];
        ai  = (ax == 2'd3) ? 2'd0 : ax;
        aj  = rmte_pkg::next_axis(3'(ai) + 3'(par));
        ak  = rmte_pkg::next_axis(3'(ai) + 3'd1 - 3'(par));
    end

    // input register
    logic                   r_v0;
    logic [8:0][EW-1:0]     r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};
    end

    assign o_busy = 1'b0;

    // element at row r, column c, scaled by the guard bits
    function automatic logic signed [XW-1:0] pick(input logic [8:0][EW-1:0] m,
                                                  input logic [1:0] r,
                                                  input logic [1:0] c);
        logic [EW-1:0] e;
        case ({r, c})
            4'b0000: e = m[0];
            4'b0001: e = m[1];
            4'b0010: e = m[2];
            4'b0100: e = m[3];
            4'b0101: e = m[4];
            4'b0110: e = m[5];
            4'b1000: e = m[6];
            4'b1001: e = m[7];
            4'b1010: e = m[8];
            default: e = '0;
        endcase
        return XW'($signed(e)) <<< rmte_pkg::GUARD;
    endfunction

    // vectors for the first chain row
    logic signed [XW-1:0] ay, ax_v, by, bx, cy, cx, mii, mki;
    always_comb begin
        mii = pick(r_m, ai, ai);
        mki = pick(r_m, ak, ai);
        cy  = -pick(r_m, aj, ak);
        cx  = pick(r_m, aj, aj);
        if (rep) begin
            ay   = pick(r_m, ai, aj);
            ax_v = pick(r_m, ai, ak);
            by   = pick(r_m, aj, ai);
            bx   = -mki;
        end else begin
            ay   = pick(r_m, aj, ai);
            ax_v = mii;
            by   = pick(r_m, ak, aj);
            bx   = pick(r_m, ak, ak);
        end
    end

    logic                   va, vb, vc;
    logic signed [XW-1:0]   mag_a, mag_b, mag_c;
    logic signed [ZW-1:0]   za, zb, zc;
    logic [2*XW-1:0]        sb_a;
    logic                   sb_b, sb_c;

    rmte_vec #(.XW(XW), .SW(2*XW), .STAGES(CORDIC_STAGES)) u_vec_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0),
        .i_y(ay), .i_x(ax_v), .i_sb({mii, mki}),
        .o_valid(va), .o_mag(mag_a), .o_z(za), .o_sb(sb_a)
    );

    rmte_vec #(.XW(XW), .SW(1), .STAGES(CORDIC_STAGES)) u_vec_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0),
        .i_y(by), .i_x(bx), .i_sb(r_v0),
        .o_valid(vb), .o_mag(mag_b), .o_z(zb), .o_sb(sb_b)
    );

    rmte_vec #(.XW(XW), .SW(1), .STAGES(CORDIC_STAGES)) u_vec_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0),
        .i_y(cy), .i_x(cx), .i_sb(r_v0),
        .o_valid(vc), .o_mag(mag_c), .o_z(zc), .o_sb(sb_c)
    );

    // gain compensation
    logic [PW-1:0] prod;
    assign prod = PW'($unsigned(mag_a)) * PW'(rmte_pkg::INVK_Q21);

    logic                   r1_valid;
    logic signed [XW-1:0]   r1_rootf, r1_mii, r1_mki;
    logic signed [ZW-1:0]   r1_za, r1_zb, r1_zc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= va;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rootf <= $signed(prod[PW-1:rmte_pkg::INVK_W]);
        r1_za    <= za;
        r1_zb    <= zb;
        r1_zc    <= zc;
        r1_mii   <= $signed(sb_a[2*XW-1:XW]);
        r1_mki   <= $signed(sb_a[XW-1:0]);
    end

    // singular test, beta vector and angle choice
    logic signed [XW-1:0] root, dy_in, dx_in;
    logic                 sing;
    logic signed [ZW-1:0] a_sel, g_sel;
    always_comb begin
        root = (r1_rootf + XW'(128)) >>> rmte_pkg::GUARD;
        sing = !(root > $signed(XW'(r_thr)));
        if (rep) begin
            dy_in = r1_rootf;
            dx_in = r1_mii;
            a_sel = sing ? r1_zc : r1_za;
            g_sel = sing ? '0 : r1_zb;
        end else begin
            dy_in = -r1_mki;
            dx_in = r1_rootf;
            a_sel = sing ? r1_zc : r1_zb;
            g_sel = sing ? '0 : r1_za;
        end
    end

    logic                 vd;
    logic signed [XW-1:0] mag_d;
    logic signed [ZW-1:0] zd;
    logic [DSW-1:0]       sb_d;

    rmte_vec #(.XW(XW), .SW(DSW), .STAGES(CORDIC_STAGES)) u_vec_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r1_valid),
        .i_y(dy_in), .i_x(dx_in), .i_sb({sing, a_sel, g_sel}),
        .o_valid(vd), .o_mag(mag_d), .o_z(zd), .o_sb(sb_d)
    );

    // rounding, parity, frame swap and beta fold
    logic signed [ZW-1:0] ra, rb, rg;
    logic signed [17:0]   fa, fb, fg, t;
    always_comb begin
        ra = ($signed(sb_d[2*ZW-1:ZW]) + rmte_pkg::ROUND_HALF) >>> rmte_pkg::OUT_LSB;
        rb = (zd + rmte_pkg::ROUND_HALF) >>> rmte_pkg::OUT_LSB;
        rg = ($signed(sb_d[ZW-1:0]) + rmte_pkg::ROUND_HALF) >>> rmte_pkg::OUT_LSB;
        fa = 18'(ra);
        fb = 18'(rb);
        fg = 18'(rg);
        if (par) begin
            fa = -fa;
            fb = -fb;
            fg = -fg;
        end
        if (fr) begin
            t  = fa;
            fa = fg;
            fg = t;
        end else begin
            t = fa;
        end
        if (r_pos && fb[17]) begin
            fb = -fb;
            fa = fa + rmte_pkg::PI_OUT;
            fg = fg + rmte_pkg::PI_OUT;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= vd;
        end
    end

    always_ff @(posedge i_clk) begin
        o_alpha_angle   <= fa[16:0];
        o_beta_angle    <= fb[15:0];
        o_gamma_angle   <= fg[16:0];
        o_near_singular <= sb_d[DSW-1];
    end

    // assertions
    `RMTE_ASSERT_NOW(a_chains_aligned, i_clk, i_rst_n, va || vb || vc,
        va && vb && vc && sb_b && sb_c, "CORDIC rows out of step")
    `RMTE_ASSERT_NEXT(a_start_taken, i_clk, i_rst_n, i_start, r_v0, "command word dropped")
    `RMTE_ASSERT_NEXT(a_result_strobe, i_clk, i_rst_n, vd, o_valid, "result word dropped")
    `RMTE_ASSERT_NOW(a_gimbal_gamma, i_clk, i_rst_n,
        o_valid && o_near_singular && !r_order[0] && !r_pos,
        o_gamma_angle == 17'sd0, "gamma not zero in gimbal lock")
endmodule
